>>> rtl/core/rlew_pkg.sv
// Shared types and constants of the RLEW word run encoder.
package rlew_pkg;

   localparam int WORD_W         = 16;
   localparam int CSR_ADDR_W     = 1;
   localparam int CSR_DATA_W     = 32;
   localparam int CMD_FIFO_DEPTH = 4;

   localparam logic [WORD_W-1:0] RUN_LIMIT     = 16'hFFFF;
   localparam logic [WORD_W-1:0] SHORT_RUN_MAX = 16'd3;

   localparam logic [CSR_ADDR_W-1:0] CSR_TAG_WORD = 1'b0;

   typedef struct packed {
      logic [WORD_W-1:0] in_word;
      logic              in_last;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_word;
      logic              item_done;
      logic              stream_end;
   } rsp_type;

   typedef struct packed {
      logic              vld;
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] count;
   } run_type;

   // Runs closed by one transaction: the run ended by a differing word,
   // then the run ended by the count limit or the last-word mark.
   typedef struct packed {
      run_type run_a;
      run_type run_b;
      logic    last;
   } cmd_type;

endpackage

>>> rtl/core/rlew_front.sv
// Front end: tracks the open run and issues closed runs as commands.
module rlew_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rlew_pkg::req_type  req_item,
   input  logic               cmd_full,
   output logic               cmd_push,
   output rlew_pkg::cmd_type  cmd_data
);

   logic [rlew_pkg::WORD_W-1:0] run_value_ff, run_value_in;
   logic [rlew_pkg::WORD_W-1:0] run_count_ff, run_count_in;
   logic [rlew_pkg::WORD_W-1:0] new_value, new_count;
   logic                        accept, close_a, close_b, restart;

   assign accept  = push && !cmd_full;
   assign close_a = (run_count_ff != '0) && (req_item.in_word != run_value_ff);
   assign restart = (run_count_ff == '0) || close_a;

   assign new_value = restart ? req_item.in_word : run_value_ff;
   assign new_count = restart ? {{(rlew_pkg::WORD_W-1){1'b0}}, 1'b1}
                              : run_count_ff + 1'b1;
   assign close_b   = (new_count == rlew_pkg::RUN_LIMIT) || req_item.in_last;

   always_comb begin
      run_value_in = run_value_ff;
      run_count_in = run_count_ff;
      if (accept) begin
         run_value_in = new_value;
         run_count_in = close_b ? '0 : new_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff <= '0;
         run_count_ff <= '0;
      end else begin
         run_value_ff <= run_value_in;
         run_count_ff <= run_count_in;
      end
   end

   assign cmd_push            = accept && (close_a || close_b);
   assign cmd_data.run_a.vld   = close_a;
   assign cmd_data.run_a.value = run_value_ff;
   assign cmd_data.run_a.count = run_count_ff;
   assign cmd_data.run_b.vld   = close_b;
   assign cmd_data.run_b.value = new_value;
   assign cmd_data.run_b.count = new_count;
   assign cmd_data.last        = req_item.in_last;

endmodule

>>> rtl/core/rlew_cmd_fifo.sv
// Short command queue between front end and back end.
module rlew_cmd_fifo #(
   parameter int DEPTH = rlew_pkg::CMD_FIFO_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  rlew_pkg::cmd_type wr_data,
   input  logic              rd_en,
   output rlew_pkg::cmd_type rd_data,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   rlew_pkg::cmd_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];

endmodule

>>> rtl/core/rlew_back.sv
// Back end: expands closed runs into output words, one word per cycle while the output register is free or popped.
module rlew_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rlew_pkg::WORD_W-1:0] tag_word,
   input  logic                        cmd_empty,
   input  rlew_pkg::cmd_type           cmd_data,
   output logic                        cmd_pop,
   input  logic                        pop,
   output logic                        empty,
   output rlew_pkg::rsp_type           rsp_item
);

   logic                        phase_ff, phase_in;
   logic [1:0]                  idx_ff, idx_in;
   logic                        out_vld_ff, out_vld_in;
   rlew_pkg::rsp_type           out_ff, out_in;
   logic                        eff_phase, triple, run_end, cmd_end, can_load, emit;
   rlew_pkg::run_type           cur;
   logic [1:0]                  last_idx;
   logic [rlew_pkg::WORD_W-1:0] word;

   assign eff_phase = phase_ff || !cmd_data.run_a.vld;
   assign cur       = eff_phase ? cmd_data.run_b : cmd_data.run_a;
   assign triple    = (cur.count > rlew_pkg::SHORT_RUN_MAX) || (cur.value == tag_word);
   assign last_idx  = triple ? 2'd2 : cur.count[1:0] - 2'd1;
   assign run_end   = (idx_ff == last_idx);
   assign cmd_end   = run_end && (eff_phase || !cmd_data.run_b.vld);

   always_comb begin
      word = cur.value;
      if (triple) begin
         case (idx_ff)
            2'd0:    word = tag_word;
            2'd1:    word = cur.count;
            default: word = cur.value;
         endcase
      end
   end

   assign can_load = !out_vld_ff || pop;
   assign emit     = !cmd_empty && can_load;
   assign cmd_pop  = emit && cmd_end;

   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (pop && out_vld_ff) begin
         out_vld_in = 1'b0;
      end
      if (emit) begin
         out_vld_in        = 1'b1;
         out_in.out_word   = word;
         out_in.item_done  = cmd_end;
         out_in.stream_end = cmd_end && cmd_data.last;
         if (cmd_end) begin
            phase_in = 1'b0;
            idx_in   = '0;
         end else if (run_end) begin
            phase_in = 1'b1;
            idx_in   = '0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 1'b0;
         idx_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign empty    = !out_vld_ff;
   assign rsp_item = out_ff;

endmodule

>>> rtl/core/rlew_word_run_encoder.sv
// Top level of the RLEW 16-bit word run-length encoder.
//
// Input queue port: req_item (word and last-word mark) is taken when push is
// high and full is low. Result queue port: while empty is low, rsp_item holds
// the oldest compressed word; it is taken when pop is high. item_done marks
// the last word caused by an input transaction, stream_end the final word of
// a compressed stream. A transaction that only extends a run gives no words.
// The tag word sits in a register at address 0 of the APB-style port.
// Throughput: one input transaction per cycle while full is low, set by the run
// tracker; the back end writes one output word per cycle unless the receiver
// stalls, so a transaction that closes runs gives 1 to 6 words and the command
// queue (CMD_FIFO_DEPTH entries) absorbs the bursts. The first word of a
// transaction passes through the command queue and then the output register.
// If the receiver stalls, words wait in the output register, the queue
// fills and full rises. Reset empties both queues, clears the open run and
// sets the tag word to 0.
module rlew_word_run_encoder #(
   parameter int FIFO_DEPTH = rlew_pkg::CMD_FIFO_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  rlew_pkg::req_type               req_item,
   output logic                            empty,
   input  logic                            pop,
   output rlew_pkg::rsp_type               rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rlew_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rlew_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rlew_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   logic [rlew_pkg::WORD_W-1:0] tag_word_ff, tag_word_in;
   logic                        csr_wr;
   logic                        cmd_push, cmd_pop, cmd_full, cmd_empty;
   rlew_pkg::cmd_type           cmd_wdata, cmd_rdata;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr == rlew_pkg::CSR_TAG_WORD);

   assign tag_word_in = csr_wr ? pwdata[rlew_pkg::WORD_W-1:0] : tag_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_word_ff <= '0;
      end else begin
         tag_word_ff <= tag_word_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == rlew_pkg::CSR_TAG_WORD) begin
         prdata = {{(rlew_pkg::CSR_DATA_W-rlew_pkg::WORD_W){1'b0}}, tag_word_ff};
      end
   end

   assign full = cmd_full;

   rlew_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_item (req_item),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wdata)
   );

   rlew_cmd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_wdata),
      .rd_en   (cmd_pop),
      .rd_data (cmd_rdata),
      .full    (cmd_full),
      .empty   (cmd_empty)
   );

   rlew_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tag_word  (tag_word_ff),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rdata),
      .cmd_pop   (cmd_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp_item  (rsp_item)
   );

endmodule

>>> sim/tb.sv
// Self-checking testbench for the RLEW 16-bit word run-length encoder.
`timescale 1ns / 100ps

module tb;

   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned DRAIN_WAIT  = 20;
   localparam logic [rlew_pkg::CSR_ADDR_W-1:0] CSR_UNMAPPED = ~rlew_pkg::CSR_TAG_WORD;

   class rlew_expected_words;
      logic [rlew_pkg::WORD_W-1:0] tag;
      logic [rlew_pkg::WORD_W-1:0] run_value;
      logic [rlew_pkg::WORD_W-1:0] run_count;
      rlew_pkg::rsp_type           expected_words[$];
      rlew_pkg::rsp_type           step_words[$];
      int unsigned                 errors;

      function new();
         tag       = '0;
         run_value = '0;
         run_count = '0;
         errors    = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function void put(logic [rlew_pkg::WORD_W-1:0] w);
         rlew_pkg::rsp_type e;
         e.out_word   = w;
         e.item_done  = 1'b0;
         e.stream_end = 1'b0;
         step_words.push_back(e);
      endfunction

      function void close_run();
         if (run_count == '0) return;
         if (run_count > rlew_pkg::SHORT_RUN_MAX || run_value == tag) begin
            put(tag);
            put(run_count);
            put(run_value);
         end else begin
            for (int i = 0; i < int'(run_count); i++) put(run_value);
         end
         run_count = '0;
      endfunction

      // predict the words caused by one accepted input transaction
      function void take_word(rlew_pkg::req_type r);
         int last_idx;
         step_words.delete();
         if (run_count != '0 && r.in_word != run_value) close_run();
         if (run_count == '0) begin
            run_value = r.in_word;
            run_count = {{(rlew_pkg::WORD_W-1){1'b0}}, 1'b1};
         end else begin
            run_count = run_count + 1'b1;
         end
         if (run_count == rlew_pkg::RUN_LIMIT || r.in_last) close_run();
         last_idx = step_words.size() - 1;
         if (last_idx >= 0) begin
            step_words[last_idx].item_done  = 1'b1;
            step_words[last_idx].stream_end = r.in_last;
         end
         foreach (step_words[i]) expected_words.push_back(step_words[i]);
      endfunction

      function void match_word(rlew_pkg::rsp_type got);
         rlew_pkg::rsp_type want;
         if (expected_words.size() == 0) begin
            flag($sformatf("unexpected word %h done=%b end=%b",
                           got.out_word, got.item_done, got.stream_end));
            return;
         end
         want = expected_words.pop_front();
         if (got.out_word !== want.out_word || got.item_done !== want.item_done ||
             got.stream_end !== want.stream_end)
            flag($sformatf("mismatch: expected %h done=%b end=%b, got %h done=%b end=%b",
                           want.out_word, want.item_done, want.stream_end,
                           got.out_word, got.item_done, got.stream_end));
      endfunction

      function int unsigned outstanding();
         return expected_words.size();
      endfunction
   endclass

   logic                            clock    = 1'b0;
   logic                            reset    = 1'b1;
   logic                            push     = 1'b0;
   rlew_pkg::req_type               req_item = '0;
   logic                            pop      = 1'b0;
   logic                            psel     = 1'b0;
   logic                            penable  = 1'b0;
   logic                            pwrite   = 1'b0;
   logic [rlew_pkg::CSR_ADDR_W-1:0] paddr    = '0;
   logic [rlew_pkg::CSR_DATA_W-1:0] pwdata   = '0;
   logic                            full;
   logic                            empty;
   rlew_pkg::rsp_type               rsp_item;
   logic [rlew_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   bit                              idle_on = 1'b1;
   int unsigned                     quiet_cycles = 0;
   rlew_expected_words              sb = new();

   rlew_word_run_encoder DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog: cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic logic [rlew_pkg::WORD_W-1:0] rand_word();
      logic [31:0] r32;
      r32 = $urandom;
      return r32[rlew_pkg::WORD_W-1:0];
   endfunction

   initial begin : drain
      int unsigned n;
      wait (!reset);
      forever begin
         if (idle_on && $urandom_range(0, 2) == 0) begin
            pop <= 1'b0;
            n = $urandom_range(1, 17);
         end else begin
            pop <= 1'b1;
            n = $urandom_range(1, 24);
         end
         repeat (n) begin
            @(posedge clock);
            if (pop && !empty) sb.match_word(rsp_item);
         end
      end
   end

   task automatic send_item(rlew_pkg::req_type r);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.take_word(r);
   endtask

   task automatic send(logic [rlew_pkg::WORD_W-1:0] w, logic last);
      rlew_pkg::req_type r;
      r.in_word = w;
      r.in_last = last;
      send_item(r);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [rlew_pkg::CSR_ADDR_W-1:0] a,
                            logic [rlew_pkg::CSR_DATA_W-1:0] d);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= a;
      pwdata  <= d;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (a == rlew_pkg::CSR_TAG_WORD) sb.tag = d[rlew_pkg::WORD_W-1:0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check_tag();
      logic [rlew_pkg::CSR_DATA_W-1:0] got;
      logic [rlew_pkg::CSR_DATA_W-1:0] want;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= rlew_pkg::CSR_TAG_WORD;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got  = prdata;
      want = {{(rlew_pkg::CSR_DATA_W-rlew_pkg::WORD_W){1'b0}}, sb.tag};
      if (got !== want)
         sb.flag($sformatf("tag readback: expected %h, got %h", want, got));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_tag(logic [rlew_pkg::WORD_W-1:0] t);
      logic [rlew_pkg::CSR_DATA_W-1:0] d;
      d = $urandom;
      d[rlew_pkg::WORD_W-1:0] = t;
      csr_write(rlew_pkg::CSR_TAG_WORD, d);
      csr_check_tag();
   endtask

   // runs of random length and content, with stray last marks as noise
   task automatic send_random_runs(int unsigned n_items);
      int unsigned                 sent;
      int unsigned                 run_len;
      logic [rlew_pkg::WORD_W-1:0] value;
      logic [rlew_pkg::WORD_W-1:0] prev_value;
      logic                        last;
      sent       = 0;
      prev_value = '0;
      while (sent < n_items) begin
         case ($urandom_range(0, 7))
            0:       value = sb.tag;
            1:       value = '0;
            2:       value = '1;
            3:       value = prev_value;
            default: value = rand_word();
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: run_len = $urandom_range(1, 4);
            7, 8:                run_len = $urandom_range(5, 12);
            default:             run_len = $urandom_range(13, 40);
         endcase
         for (int i = 0; i < int'(run_len); i++) begin
            if (i == int'(run_len) - 1) last = ($urandom_range(0, 7) == 0);
            else                        last = ($urandom_range(0, 39) == 0);
            send(value, last);
            sent++;
         end
         prev_value = value;
      end
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tag stays at its reset value of zero
      csr_check_tag();
      send(16'h0000, 1'b0);
      send(16'h0001, 1'b0);
      send(16'h0001, 1'b1);
      send(16'hFFFF, 1'b1);
      repeat (4) send(16'h8000, 1'b0);
      send(16'h7FFF, 1'b1);
      repeat (4) send(16'h0005, 1'b0);
      send(16'h0000, 1'b1);
      send(16'h0002, 1'b0);
      send(16'h0003, 1'b0);
      send(16'h0003, 1'b0);
      send(16'h0004, 1'b1);
      wait_drained();

      // write to an unmapped address must leave the tag alone
      csr_write(CSR_UNMAPPED, 32'hA5A5_1234);
      csr_check_tag();

      // tag changes while a run is open
      send(16'h00AA, 1'b0);
      send(16'h00AA, 1'b0);
      wait_drained();
      set_tag(16'h00AA);
      send(16'h00BB, 1'b1);
      wait_drained();

      set_tag(16'hFFFF);
      send_random_runs(120);
      wait_drained();
      set_tag(rand_word());
      send_random_runs(120);
      wait_drained();
      set_tag(16'h0000);
      send_random_runs(120);
      wait_drained();

      idle_on = 1'b0;
      set_tag(rand_word());
      send_random_runs(110);
      send(rand_word(), 1'b1);
      push <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
